@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the range status classifier.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/rsc_pkg.sv @@
// Package for the range status classifier: widths, register indexes, status codes,
// the pipeline payload type and the division and priority functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  localparam int unsigned RATE_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned RATE_SHIFT = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // Quotient bits resolved by each divider stage; must divide RATE_W.
  localparam int unsigned RSC_DIV_STEPS = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_THR  = 2'd3;

  // Bits of the enable mask.
  localparam int unsigned EN_SIGMA  = 0;
  localparam int unsigned EN_CLIP   = 1;
  localparam int unsigned EN_IGNORE = 2;

  typedef enum logic [2:0] {
    RS_VALID,
    RS_SIGMA,
    RS_SIGNAL,
    RS_MIN_RANGE,
    RS_PHASE,
    RS_HARDWARE,
    RS_NO_UPDATE
  } rs_code_t;

  // Partial remainder and the dividend that shifts into the quotient.
  typedef struct packed {
    logic [COUNT_W-1:0] rem;
    logic [RATE_W-1:0]  quo;
  } rsc_div_t;

  typedef struct packed {
    rsc_div_t           div;
    logic [COUNT_W-1:0] divisor;
    logic [CODE_W-1:0]  dcode;
    logic               sig_f;
    logic               clip_f;
    logic               ign_en;
  } rsc_stage_t;

  // One restoring division step. The remainder stays below a nonzero divisor,
  // so it fits in COUNT_W bits after the subtraction.
  function automatic rsc_div_t rsc_div_step(rsc_div_t s, logic [COUNT_W-1:0] dvs);
    logic [COUNT_W:0] trial;
    logic [COUNT_W:0] diff;
    rsc_div_t         r;
    trial = {s.rem, s.quo[RATE_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      r.rem = diff[COUNT_W-1:0];
      r.quo = {s.quo[RATE_W-2:0], 1'b1};
    end else begin
      r.rem = trial[COUNT_W-1:0];
      r.quo = {s.quo[RATE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Priority mapping of the device code and the limit failures.
  function automatic rs_code_t rsc_map(logic [CODE_W-1:0] d, logic clip_f,
                                       logic ign_f, logic sig_f);
    rs_code_t c;
    if (d inside {4'd0, 4'd5, 4'd7, [4'd12:4'd15]}) begin
      c = RS_NO_UPDATE;
    end else if (d inside {[4'd1:4'd3]}) begin
      c = RS_HARDWARE;
    end else if (d inside {4'd6, 4'd9}) begin
      c = RS_PHASE;
    end else if ((d inside {4'd8, 4'd10}) || clip_f) begin
      c = RS_MIN_RANGE;
    end else if (d == 4'd4 || ign_f) begin
      c = RS_SIGNAL;
    end else if (sig_f) begin
      c = RS_SIGMA;
    end else begin
      c = RS_VALID;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/range_status_classifier.sv @@
// Range status classifier top level: limit checks, pipelined per-SPAD rate divider
// and status priority mapping. Depends on rsc_pkg and assert_macros.svh.
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+---------------------
//  command   | start, busy, device_status .. spad_count        | start && !busy
//  result    | result_valid, range_status .. rate_per_spad     | strobe, one cycle
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid && cfg_ready
//
// A new command can be taken in every cycle; busy stays low.
// The pipeline has one input stage, one stage per DIV_STEPS quotient bits of the restoring
// divider and one output stage.
// The divider stage chain sets the latency; throughput is one transfer per cycle.
// Reset clears the stage valid bits, the result strobe and the limit registers.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module range_status_classifier
  import rsc_pkg::*;
#(
  parameter int unsigned DIV_STEPS = RSC_DIV_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           device_status,
  input  logic [RATE_W-1:0]    sigma_estimate,
  input  logic [RATE_W-1:0]    peak_ref_rate,
  input  logic [RATE_W-1:0]    return_rate,
  input  logic [COUNT_W-1:0]   spad_count,
  output logic                 result_valid,
  output logic [2:0]           range_status,
  output logic                 sigma_fail,
  output logic                 clip_fail,
  output logic                 ignore_fail,
  output logic [RATE_W-1:0]    rate_per_spad,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  localparam int unsigned NSTAGE = RATE_W / DIV_STEPS;

  logic [2:0]        enable_mask;
  logic [RATE_W-1:0] sigma_limit;
  logic [RATE_W-1:0] ref_clip_limit;
  logic [RATE_W-1:0] ignore_threshold;

  rsc_stage_t        pipe [0:NSTAGE];
  logic [NSTAGE:0]   vld;

  logic              take;
  logic [RATE_W-1:0] per_spad;
  logic              ign_f;
  rs_code_t          code;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask      <= '0;
      sigma_limit      <= '0;
      ref_clip_limit   <= '0;
      ignore_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE_MASK: enable_mask      <= cfg_data[2:0];
        REG_SIGMA_LIMIT: sigma_limit      <= cfg_data;
        REG_CLIP_LIMIT:  ref_clip_limit   <= cfg_data;
        REG_IGNORE_THR:  ignore_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-1:0], take};
    end
  end

  // Input stage: the two threshold checks and the shifted dividend.
  always_ff @(posedge clk) begin
    pipe[0].div.rem <= '0;
    pipe[0].div.quo <= {return_rate[RATE_W-RATE_SHIFT-1:0], {RATE_SHIFT{1'b0}}};
    pipe[0].divisor <= spad_count;
    pipe[0].dcode   <= device_status[6:3];
    pipe[0].sig_f   <= enable_mask[EN_SIGMA] && (sigma_estimate > sigma_limit);
    pipe[0].clip_f  <= enable_mask[EN_CLIP] && (peak_ref_rate > ref_clip_limit);
    pipe[0].ign_en  <= enable_mask[EN_IGNORE];
  end

  for (genvar k = 1; k <= NSTAGE; k++) begin : g_div
    rsc_div_t acc;

    always_comb begin
      acc = pipe[k-1].div;
      for (int unsigned j = 0; j < DIV_STEPS; j++) begin
        acc = rsc_div_step(acc, pipe[k-1].divisor);
      end
    end

    always_ff @(posedge clk) begin
      pipe[k].div     <= acc;
      pipe[k].divisor <= pipe[k-1].divisor;
      pipe[k].dcode   <= pipe[k-1].dcode;
      pipe[k].sig_f   <= pipe[k-1].sig_f;
      pipe[k].clip_f  <= pipe[k-1].clip_f;
      pipe[k].ign_en  <= pipe[k-1].ign_en;
    end
  end

  // A zero count leaves an all-ones quotient, which the rate replaces with zero.
  always_comb begin
    per_spad = '0;
    if (pipe[NSTAGE].ign_en && (pipe[NSTAGE].divisor != '0)) begin
      per_spad = pipe[NSTAGE].div.quo;
    end
    ign_f = pipe[NSTAGE].ign_en && (per_spad < ignore_threshold);
    code  = rsc_map(pipe[NSTAGE].dcode, pipe[NSTAGE].clip_f, ign_f, pipe[NSTAGE].sig_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vld[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    range_status  <= code;
    sigma_fail    <= pipe[NSTAGE].sig_f;
    clip_fail     <= pipe[NSTAGE].clip_f;
    ignore_fail   <= ign_f;
    rate_per_spad <= per_spad;
  end

  `ASSERT_NEXT(a_strobe_follows_stage, vld[NSTAGE], result_valid)
  `ASSERT_IMPL(a_valid_code_no_fail, result_valid && range_status == RS_VALID,
               !sigma_fail && !clip_fail && !ignore_fail)
  `ASSERT_IMPL(a_clip_overrides, result_valid && clip_fail,
               range_status != RS_VALID && range_status != RS_SIGMA &&
               range_status != RS_SIGNAL)

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for range_status_classifier: directed and random readings,
// limit settings written between phases, results checked against an in-bench predictor.
// Depends on rsc_pkg and the range_status_classifier RTL.
`timescale 1ns / 1ps

module testbench;
  import rsc_pkg::*;

  localparam int unsigned LATENCY     = RATE_W / RSC_DIV_STEPS + 2;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PER_SETTING = 108;

  typedef struct packed {
    logic [7:0]         status;
    logic [RATE_W-1:0]  sigma;
    logic [RATE_W-1:0]  ref_rate;
    logic [RATE_W-1:0]  rtn_rate;
    logic [COUNT_W-1:0] count;
  } reading_t;

  typedef struct packed {
    rs_code_t          status;
    logic              sig_f;
    logic              clip_f;
    logic              ign_f;
    logic [RATE_W-1:0] per_spad;
  } verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [7:0]           device_status;
  logic [RATE_W-1:0]    sigma_estimate;
  logic [RATE_W-1:0]    peak_ref_rate;
  logic [RATE_W-1:0]    return_rate;
  logic [COUNT_W-1:0]   spad_count;
  logic                 result_valid;
  logic [2:0]           range_status;
  logic                 sigma_fail;
  logic                 clip_fail;
  logic                 ignore_fail;
  logic [RATE_W-1:0]    rate_per_spad;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0]    cfg_data;

  // Local copy of the limit registers, updated on each configuration transfer.
  logic [2:0]        enable_mask;
  logic [RATE_W-1:0] sigma_lim;
  logic [RATE_W-1:0] clip_lim;
  logic [RATE_W-1:0] ignore_thr;

  verdict_t    expected_verdicts[$];
  verdict_t    head_verdict;
  int unsigned failures;
  int unsigned readings_sent;
  int unsigned verdicts_checked;
  int unsigned settings_used;
  int unsigned idle_pct;
  int unsigned stall_cycles;

  range_status_classifier uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .device_status(device_status),
    .sigma_estimate(sigma_estimate),
    .peak_ref_rate(peak_ref_rate),
    .return_rate(return_rate),
    .spad_count(spad_count),
    .result_valid(result_valid),
    .range_status(range_status),
    .sigma_fail(sigma_fail),
    .clip_fail(clip_fail),
    .ignore_fail(ignore_fail),
    .rate_per_spad(rate_per_spad),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic verdict_t classify_reading(reading_t r);
    verdict_t          v;
    logic [RATE_W-1:0] scaled;
    logic [3:0]        dcode;
    v.sig_f    = enable_mask[EN_SIGMA] && (r.sigma > sigma_lim);
    v.clip_f   = enable_mask[EN_CLIP] && (r.ref_rate > clip_lim);
    v.ign_f    = 1'b0;
    v.per_spad = '0;
    if (enable_mask[EN_IGNORE]) begin
      // The shift is done at 32 bits, so high bits of the return rate fall away.
      scaled = r.rtn_rate << RATE_SHIFT;
      if (r.count != '0) begin
        v.per_spad = scaled / r.count;
      end
      v.ign_f = v.per_spad < ignore_thr;
    end
    dcode = r.status[6:3];
    case (dcode)
      4'd0, 4'd5, 4'd7, 4'd12, 4'd13, 4'd14, 4'd15: v.status = RS_NO_UPDATE;
      4'd1, 4'd2, 4'd3: v.status = RS_HARDWARE;
      4'd6, 4'd9: v.status = RS_PHASE;
      4'd8, 4'd10: v.status = RS_MIN_RANGE;
      4'd4: v.status = v.clip_f ? RS_MIN_RANGE : RS_SIGNAL;
      default: begin
        if (v.clip_f) begin
          v.status = RS_MIN_RANGE;
        end else if (v.ign_f) begin
          v.status = RS_SIGNAL;
        end else if (v.sig_f) begin
          v.status = RS_SIGMA;
        end else begin
          v.status = RS_VALID;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [RATE_W-1:0] value_near(logic [RATE_W-1:0] lim);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return lim;
      2: return lim + $urandom_range(1, 3);
      3: return lim - $urandom_range(1, 3);
      4: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] random_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic reading_t random_reading();
    reading_t          r;
    logic [47:0]       product;
    int unsigned       pick;
    r.status = 8'($urandom);
    pick = $urandom_range(0, 19);
    // Most readings carry the code that lets the limit checks decide the status.
    if (pick < 12) begin
      r.status[6:3] = 4'd11;
    end else if (pick < 15) begin
      r.status[6:3] = 4'd4;
    end
    r.sigma    = value_near(sigma_lim);
    r.ref_rate = value_near(clip_lim);
    case ($urandom_range(0, 7))
      0: r.count = '0;
      1: r.count = '1;
      2, 3: r.count = COUNT_W'($urandom_range(1, 16) << $urandom_range(0, 8));
      default: r.count = COUNT_W'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) begin
      // Aim the per-SPAD rate at the ignore threshold.
      product    = 48'(ignore_thr) * 48'(r.count);
      r.rtn_rate = product[RATE_W+RATE_SHIFT-1:RATE_SHIFT] + $urandom_range(0, 2);
    end else begin
      r.rtn_rate = $urandom >> $urandom_range(0, 31);
    end
    return r;
  endfunction

  task automatic send_reading(input reading_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start          <= 1'b0;
      device_status  <= 8'($urandom);
      sigma_estimate <= $urandom;
      peak_ref_rate  <= $urandom;
      return_rate    <= $urandom;
      spad_count     <= COUNT_W'($urandom);
      @(posedge clk);
    end
    start          <= 1'b1;
    device_status  <= r.status;
    sigma_estimate <= r.sigma;
    peak_ref_rate  <= r.ref_rate;
    return_rate    <= r.rtn_rate;
    spad_count     <= r.count;
    do @(posedge clk); while (busy);
    expected_verdicts.push_back(classify_reading(r));
    readings_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE_MASK: enable_mask = data[2:0];
      REG_SIGMA_LIMIT: sigma_lim = data;
      REG_CLIP_LIMIT:  clip_lim = data;
      REG_IGNORE_THR:  ignore_thr = data;
      default: ;
    endcase
  endtask

  // Registers are only written once every outstanding result has come back.
  task automatic program_limits(input logic [RATE_W-1:0] mask_word,
                                input logic [RATE_W-1:0] sig,
                                input logic [RATE_W-1:0] clip,
                                input logic [RATE_W-1:0] thr);
    drain_results();
    write_register(REG_ENABLE_MASK, mask_word);
    write_register(REG_SIGMA_LIMIT, sig);
    write_register(REG_CLIP_LIMIT, clip);
    write_register(REG_IGNORE_THR, thr);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                             input logic [RATE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      failures++;
    end
  endtask

  // With every limit register still at its reset value no check is active.
  task automatic test_reset_defaults();
    send_reading('{8'h58, '1, '1, '1, 16'h0001});
    send_reading('{8'hDF, 32'h0, 32'h0, 32'h0, 16'h0});
  endtask

  task automatic test_device_codes();
    reading_t r;
    program_limits(32'hFFFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0000_0100);
    for (int d = 0; d < 16; d++) begin
      r.status   = {d[0], d[3:0], d[2:0]};
      r.sigma    = d[0] ? '1 : '0;
      r.ref_rate = d[1] ? '1 : '0;
      r.rtn_rate = d[2] ? '1 : '0;
      r.count    = 16'h0100;
      send_reading(r);
    end
  endtask

  task automatic test_limit_edges();
    // Values equal to their limits pass; a count of one gives exactly the threshold.
    send_reading('{8'hDF, 32'h0001_0000, 32'h0002_0000, 32'h0000_0001, 16'h0001});
    send_reading('{8'h58, 32'h0001_0001, 32'h0002_0000, 32'h0000_0001, 16'h0001});
    // A zero SPAD count leaves the rate at zero, below the threshold.
    send_reading('{8'h58, 32'h0, 32'h0, '1, 16'h0000});
    send_reading('{8'hD8, 32'h0, '1, 32'h0000_0001, 16'h0001});
    // Shift overflow: the top byte of the return rate is lost before the divide.
    send_reading('{8'h5F, 32'h0, 32'h0, '1, '1});
    send_reading('{8'h58, 32'h0, 32'h0, '1, 16'h0001});
    send_reading('{8'hDE, '1, '1, 32'h0, 16'h0005});
  endtask

  task automatic test_random_traffic();
    int unsigned idle_rates[4] = '{0, 54, 14, 0};
    for (int phase = 0; phase < 4; phase++) begin
      for (int setting = 0; setting < 3; setting++) begin
        case (setting)
          0: program_limits($urandom, random_limit(), random_limit(), random_limit());
          1: program_limits($urandom | 32'h7, random_limit(), random_limit(),
                            random_limit());
          default: begin
            if (phase % 2 == 1) begin
              program_limits('1, '1, '1, '1);
            end else begin
              program_limits(32'h7, '0, '0, '0);
            end
          end
        endcase
        idle_pct = idle_rates[phase];
        for (int n = 0; n < PER_SETTING; n++) begin
          send_reading(random_reading());
          if ($urandom_range(0, 99) == 0) begin
            drain_results();
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with no reading outstanding: range_status %0d",
               range_status);
        failures++;
      end else begin
        head_verdict = expected_verdicts.pop_front();
        check_field("range_status", head_verdict.status, range_status);
        check_field("sigma_fail", head_verdict.sig_f, sigma_fail);
        check_field("clip_fail", head_verdict.clip_f, clip_fail);
        check_field("ignore_fail", head_verdict.ign_f, ignore_fail);
        check_field("rate_per_spad", head_verdict.per_spad, rate_per_spad);
        verdicts_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    failures         = 0;
    readings_sent    = 0;
    verdicts_checked = 0;
    settings_used    = 0;
    idle_pct         = 0;
    stall_cycles     = 0;
    enable_mask      = '0;
    sigma_lim        = '0;
    clip_lim         = '0;
    ignore_thr       = '0;
    rst            <= 1'b1;
    start          <= 1'b0;
    device_status  <= '0;
    sigma_estimate <= '0;
    peak_ref_rate  <= '0;
    return_rate    <= '0;
    spad_count     <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_device_codes();
    test_limit_edges();
    test_random_traffic();

    drain_results();
    repeat (LATENCY + 2) @(posedge clk);
    $display("Sent %0d readings under %0d limit settings; %0d results checked.",
             readings_sent, settings_used, verdicts_checked);
    $display("Covered all sixteen device codes, limit edges and sender idling at 0/14/54%%.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
